// ===== hdl/lir_pkg.sv =====
package lir_pkg;

  localparam int SAMPLE_W = 32;
  localparam int STEP_W   = 25;
  localparam int BYTES_W  = 3;
  localparam int VALUE_W  = 9;
  localparam int COUNT_W  = 24;
  localparam int PHASE_W  = STEP_W + 1;
  localparam int OUT_W    = 40;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 25'd65536;
  localparam logic [BYTES_W-1:0] BYTES_RESET = 3'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  typedef enum logic {
    REG_PHASE_STEP   = 1'b0,
    REG_SAMPLE_BYTES = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic dif_en;
    logic mul_en;
    logic sum_en;
    logic rnd_en;
  } lir_ctrl_t;

endpackage

// ===== hdl/linear_interp_resampler.sv =====
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: sample[31:0]; tuser: start_req
// m_*       out  m_tvalid/m_tready  tdata: value[8:0], point_count[32:9]; tlast: last_in_run
// apb       in   psel/penable       phase_step @0x0, sample_bytes @0x4
//
// An item that starts a waveform or falls in a downsampling gap is taken in IDLE and emits no output.
// Otherwise each output passes through four steps of the shared multiply/add/shift unit
// (multiply, sum, round and shift, hold), and HOLD waits while m_tready stays low;
// an item yields n outputs, n at most MAX_RUN.
// s_tready is high only between items. rst is synchronous and clears all control state.
module linear_interp_resampler #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_RUN   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample[31:0]
  input  logic        s_tuser,   // start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // value[8:0], point_count[32:9], zero[39:33]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lir_pkg::*;

  localparam int N_W = $clog2(MAX_RUN + 1);
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    MUL  = 5'b00010,
    SUM  = 5'b00100,
    RND  = 5'b01000,
    HOLD = 5'b10000
  } state_t;

  state_t                     state;
  logic [STEP_W-1:0]          phase_step;
  logic [BYTES_W-1:0]         sample_bytes;
  logic signed [SAMPLE_W-1:0] prev;
  logic signed [SAMPLE_W-1:0] cur;
  logic [PHASE_W-1:0]         phase;
  logic [PHASE_W-1:0]         phase_next;
  logic [COUNT_W-1:0]         emitted;
  logic [COUNT_W-1:0]         point_count;
  logic                       have_prev;
  logic [N_W-1:0]             n;
  logic [N_W-1:0]             n_next;
  logic                       last;
  logic                       in_acc;
  logic signed [VALUE_W-1:0]  value;
  lir_ctrl_t                  ctrl;

  lir_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .phase_step   (phase_step),
    .sample_bytes (sample_bytes)
  );

  lir_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
    .clk          (clk),
    .ctrl         (ctrl),
    .prev_in      (prev),
    .cur_in       ($signed(s_tdata)),
    .frac         (phase[FRAC_BITS-1:0]),
    .sample_bytes (sample_bytes),
    .value        (value)
  );

  assign s_tready = (state == IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign m_tvalid = (state == HOLD);
  assign m_tlast  = last;
  assign m_tdata  = {{(OUT_W-VALUE_W-COUNT_W){1'b0}}, point_count, value};

  assign phase_next = phase + {1'b0, phase_step};
  assign n_next     = n + 1'b1;

  always_comb begin
    ctrl        = '0;
    ctrl.dif_en = in_acc;
    ctrl.mul_en = (state == MUL);
    ctrl.sum_en = (state == SUM);
    ctrl.rnd_en = (state == RND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      prev      <= '0;
      phase     <= '0;
      have_prev <= 1'b0;
      emitted   <= '0;
      n         <= '0;
      last      <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_acc) begin
            if (s_tuser || !have_prev) begin
              prev      <= $signed(s_tdata);
              phase     <= '0;
              have_prev <= 1'b1;
              emitted   <= '0;
            end else if (phase >= PHASE_ONE) begin
              prev  <= $signed(s_tdata);
              phase <= phase - PHASE_ONE;
            end else begin
              cur   <= $signed(s_tdata);
              n     <= '0;
              state <= MUL;
            end
          end
        end
        MUL: begin
          if (emitted != COUNT_MAX) begin
            emitted <= emitted + 1'b1;
          end
          phase <= phase_next;
          n     <= n_next;
          last  <= !((phase_next < PHASE_ONE) && (n_next < N_W'(MAX_RUN)));
          state <= SUM;
        end
        SUM: begin
          state <= RND;
        end
        RND: begin
          point_count <= emitted;
          state       <= HOLD;
        end
        HOLD: begin
          if (m_tready) begin
            if (last) begin
              phase <= (phase >= PHASE_ONE) ? phase - PHASE_ONE : '0;
              prev  <= cur;
              state <= IDLE;
            end else begin
              state <= MUL;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lir_regs.sv =====
module lir_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [lir_pkg::STEP_W-1:0]    phase_step,
  output logic [lir_pkg::BYTES_W-1:0]   sample_bytes
);
  import lir_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= STEP_RESET;
      sample_bytes <= BYTES_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PHASE_STEP:   phase_step   <= pwdata[STEP_W-1:0];
        REG_SAMPLE_BYTES: sample_bytes <= pwdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PHASE_STEP:   prdata = {{(32-STEP_W){1'b0}}, phase_step};
      REG_SAMPLE_BYTES: prdata = {{(32-BYTES_W){1'b0}}, sample_bytes};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/lir_interp.sv =====
module lir_interp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  lir_pkg::lir_ctrl_t                 ctrl,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] prev_in,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] cur_in,
  input  logic [FRAC_BITS-1:0]               frac,
  input  logic [lir_pkg::BYTES_W-1:0]        sample_bytes,
  output logic signed [lir_pkg::VALUE_W-1:0] value
);
  import lir_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int NUM_W  = PROD_W + 1;

  logic signed [SAMPLE_W-1:0] base;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    bias;
  logic signed [NUM_W-1:0]    rsum;
  logic signed [NUM_W-1:0]    quot;
  logic signed [NUM_W-1:0]    shifted;
  logic [BYTES_W-1:0]         bytes_m1;
  logic [BYTES_W+2:0]         shamt;

  always_ff @(posedge clk) begin
    if (ctrl.dif_en) begin
      base <= prev_in;
      diff <= $signed({cur_in[SAMPLE_W-1], cur_in}) - $signed({prev_in[SAMPLE_W-1], prev_in});
    end
    if (ctrl.mul_en) begin
      prod <= diff * $signed({1'b0, frac});
    end
    if (ctrl.sum_en) begin
      num <= $signed({{(NUM_W-SAMPLE_W-FRAC_BITS){base[SAMPLE_W-1]}}, base, {FRAC_BITS{1'b0}}})
           + $signed({prod[PROD_W-1], prod});
    end
    if (ctrl.rnd_en) begin
      value <= shifted[VALUE_W-1:0];
    end
  end

  always_comb begin
    bias     = num[NUM_W-1] ? $signed({{(NUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                            : $signed({NUM_W{1'b0}});
    rsum     = num + bias;
    quot     = rsum >>> FRAC_BITS;
    bytes_m1 = (sample_bytes == '0) ? '0 : sample_bytes - 1'b1;
    shamt    = {bytes_m1, 3'b000};
    shifted  = quot >>> shamt;
  end

endmodule
